FILE: design/ls2_pkg.sv
`timescale 1ns / 1ps

package ls2_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // full products, their differences and the magnitudes fed to the dividers
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int DIFF_W = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  // numerator after the fraction shift, and the part above the quotient bits
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int HEAD_W = NUM_W - WORD_BITS;

  // cycles from an accepted start to the done strobe
  localparam int LATENCY = WORD_BITS + 5;

  typedef struct packed {
    logic                 big;
    logic                 neg;
    logic [WORD_BITS-1:0] quo;
  } div_res_t;

endpackage

FILE: design/linear_solve_2x2.sv
`timescale 1ns / 1ps

// Solves a 2x2 system a*x + b*y = u, c*x + d*y = v on signed Q16.16 words with
// exact full-width products; x and y are truncated toward zero and saturated,
// with overflow set when either clamps and solvable low (all zero) when the
// determinant is zero. A new item may be started every cycle: busy_o stays
// low. Each result appears on done_o after the multiply, subtract and
// magnitude stages, the two one-bit-per-stage restoring dividers and the
// output register. The receiver cannot stall.
module linear_solve_2x2 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] coef_a_i,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] coef_b_i,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] coef_c_i,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] coef_d_i,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] rhs_u_i,
  input  logic signed [ls2_pkg::WORD_BITS-1:0] rhs_v_i,
  output logic                               done_o,
  output logic                               solvable_o,
  output logic signed [ls2_pkg::WORD_BITS-1:0] sol_x_o,
  output logic signed [ls2_pkg::WORD_BITS-1:0] sol_y_o,
  output logic                               overflow_o
);

  localparam int W = ls2_pkg::WORD_BITS;
  localparam int P = ls2_pkg::PROD_W;
  localparam int D = ls2_pkg::DIFF_W;
  localparam int M = ls2_pkg::MAG_W;

  logic                start_ok;
  logic                v1_q, v2_q, v3_q;
  logic signed [P-1:0] ad_q, bc_q, ud_q, bv_q, av_q, uc_q;
  logic signed [D-1:0] det_q, nx_q, ny_q;
  logic [M-1:0]        dmag_q, xmag_q, ymag_q;
  logic                xneg_q, yneg_q, sol3_q;
  logic                sol_q [W+1];

  logic                dvx, dvy;
  ls2_pkg::div_res_t   rx, ry;
  logic [W-1:0]        limx, limy, valx, valy;
  logic                ovx, ovy;

  logic                done_q, solv_q, ovf_q;
  logic [W-1:0]        x_q, y_q;

  assign busy_o   = 1'b0;
  assign start_ok = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ad_q <= P'(coef_a_i * coef_d_i);
    bc_q <= P'(coef_b_i * coef_c_i);
    ud_q <= P'(rhs_u_i * coef_d_i);
    bv_q <= P'(coef_b_i * rhs_v_i);
    av_q <= P'(coef_a_i * rhs_v_i);
    uc_q <= P'(rhs_u_i * coef_c_i);

    det_q <= D'(ad_q) - D'(bc_q);
    nx_q  <= D'(ud_q) - D'(bv_q);
    ny_q  <= D'(av_q) - D'(uc_q);

    dmag_q <= det_q[D-1] ? M'(-det_q) : M'(det_q);
    xmag_q <= nx_q[D-1] ? M'(-nx_q) : M'(nx_q);
    ymag_q <= ny_q[D-1] ? M'(-ny_q) : M'(ny_q);
    xneg_q <= nx_q[D-1] ^ det_q[D-1];
    yneg_q <= ny_q[D-1] ^ det_q[D-1];
    sol3_q <= det_q != '0;
  end

  // solvable flag rides alongside the dividers
  always_ff @(posedge clk_i) begin
    sol_q[0] <= sol3_q;
    for (int i = 0; i < W; i++) begin
      sol_q[i+1] <= sol_q[i];
    end
  end

  ls2_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (xmag_q),
    .den_i   (dmag_q),
    .neg_i   (xneg_q),
    .valid_o (dvx),
    .res_o   (rx)
  );

  ls2_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   (ymag_q),
    .den_i   (dmag_q),
    .neg_i   (yneg_q),
    .valid_o (dvy),
    .res_o   (ry)
  );

  always_comb begin
    limx = rx.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    limy = ry.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    ovx  = rx.big || (rx.quo > limx);
    ovy  = ry.big || (ry.quo > limy);
    valx = ovx ? limx : rx.quo;
    valy = ovy ? limy : ry.quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvx && dvy;
    end
  end

  always_ff @(posedge clk_i) begin
    solv_q <= sol_q[W];
    if (sol_q[W]) begin
      x_q   <= rx.neg ? -valx : valx;
      y_q   <= ry.neg ? -valy : valy;
      ovf_q <= ovx || ovy;
    end else begin
      x_q   <= '0;
      y_q   <= '0;
      ovf_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign solvable_o = solv_q;
  assign sol_x_o    = x_q;
  assign sol_y_o    = y_q;
  assign overflow_o = ovf_q;

endmodule

FILE: design/ls2_div.sv
`timescale 1ns / 1ps

module ls2_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [ls2_pkg::MAG_W-1:0] num_i,
  input  logic [ls2_pkg::MAG_W-1:0] den_i,
  input  logic                    neg_i,
  output logic                    valid_o,
  output ls2_pkg::div_res_t       res_o
);

  localparam int W = ls2_pkg::WORD_BITS;
  localparam int M = ls2_pkg::MAG_W;

  logic [ls2_pkg::NUM_W-1:0]  n_full;
  logic [ls2_pkg::HEAD_W-1:0] head;
  logic                       big_d;

  logic         v_q   [W+1];
  logic [M-1:0] r_q   [W+1];
  logic [M-1:0] den_q [W+1];
  logic [W-1:0] t_q   [W+1];
  logic [W-1:0] q_q   [W+1];
  logic         neg_q [W+1];
  logic         big_q [W+1];

  assign n_full = {num_i, {ls2_pkg::FRAC_BITS{1'b0}}};
  assign head   = n_full[ls2_pkg::NUM_W-1 -: ls2_pkg::HEAD_W];
  // quotient needs more than the word when the top part already reaches den
  assign big_d  = M'(head) >= den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]   <= M'(head);
    den_q[0] <= den_i;
    t_q[0]   <= n_full[W-1:0];
    q_q[0]   <= '0;
    neg_q[0] <= neg_i;
    big_q[0] <= big_d;
  end

  // one quotient bit per stage, restoring
  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [M:0] cat;
    logic [M:0] dif;
    logic       ge;

    assign cat = {r_q[s], t_q[s][W-1]};
    assign dif = cat - {1'b0, den_q[s]};
    assign ge  = cat >= {1'b0, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[s+1]   <= ge ? dif[M-1:0] : cat[M-1:0];
      den_q[s+1] <= den_q[s];
      t_q[s+1]   <= {t_q[s][W-2:0], 1'b0};
      q_q[s+1]   <= {q_q[s][W-2:0], ge};
      neg_q[s+1] <= neg_q[s];
      big_q[s+1] <= big_q[s];
    end
  end

  assign valid_o   = v_q[W];
  assign res_o.big = big_q[W];
  assign res_o.neg = neg_q[W];
  assign res_o.quo = q_q[W];

endmodule

FILE: design/ls2_chk.sv
`timescale 1ns / 1ps

module ls2_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         done_o,
  input logic                         solvable_o,
  input logic [ls2_pkg::WORD_BITS-1:0] sol_x_o,
  input logic [ls2_pkg::WORD_BITS-1:0] sol_y_o,
  input logic                         overflow_o
);

  localparam int W = ls2_pkg::WORD_BITS;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i && !busy_o && rst_ni, ls2_pkg::LATENCY))
    else $error("done strobe out of step with start");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !solvable_o |-> sol_x_o == '0 && sol_y_o == '0 && !overflow_o)
    else $error("singular beat carries data");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflow_o |->
      sol_x_o == {1'b1, {(W-1){1'b0}}} || sol_x_o == {1'b0, {(W-1){1'b1}}} ||
      sol_y_o == {1'b1, {(W-1){1'b0}}} || sol_y_o == {1'b0, {(W-1){1'b1}}})
    else $error("overflow without a clamped value");

endmodule

bind linear_solve_2x2 ls2_chk u_ls2_chk (.*);

FILE: sim/linear_solve_2x2_test.sv
`timescale 1ns / 1ps

module linear_solve_2x2_test;

  localparam int W  = ls2_pkg::WORD_BITS;
  localparam int FB = ls2_pkg::FRAC_BITS;

  typedef logic signed [W-1:0] word_t;

  typedef struct {
    logic  solvable;
    word_t x;
    word_t y;
    logic  overflow;
  } solution_t;

  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // truncating quotient of (num << FB) / den, clamped to the word range
  function automatic word_t clamp_quotient(input logic signed [2*W+1:0] num,
                                           input logic signed [2*W+1:0] den,
                                           inout logic ovf);
    logic neg;
    logic [2*W+FB+1:0] n_mag, d_mag, q;
    logic [2*W+FB+1:0] lim;
    neg = num[2*W+1] ^ den[2*W+1];
    n_mag = num[2*W+1] ? -num : num;
    d_mag = den[2*W+1] ? -den : den;
    n_mag = n_mag << FB;
    q = n_mag / d_mag;
    if (num == 0) neg = 1'b0;
    lim = neg ? (1 << (W - 1)) : ((1 << (W - 1)) - 1);
    if (q > lim) begin
      ovf = 1'b1;
      q = lim;
    end
    return neg ? word_t'(-q) : word_t'(q);
  endfunction

  function automatic solution_t solve_system(input word_t a, b, c, d, u, v);
    solution_t s;
    logic signed [2*W+1:0] det, nx, ny;
    logic ovf;
    det = a * d - b * c;
    s = '{default: '0};
    if (det == 0) return s;
    ovf = 1'b0;
    nx = u * d - b * v;
    ny = a * v - u * c;
    s.solvable = 1'b1;
    s.x = clamp_quotient(nx, det, ovf);
    s.y = clamp_quotient(ny, det, ovf);
    s.overflow = ovf;
    return s;
  endfunction

  class solution_board;
    solution_t pending[$];

    function void note_system(word_t a, b, c, d, u, v);
      pending.push_back(solve_system(a, b, c, d, u, v));
    endfunction

    task check_solution(logic solvable, word_t x, word_t y, logic overflow);
      solution_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (solvable !== w.solvable) report_mismatch("solvable", solvable, w.solvable);
      if (x !== w.x) report_mismatch("sol_x", x, w.x);
      if (y !== w.y) report_mismatch("sol_y", y, w.y);
      if (overflow !== w.overflow) report_mismatch("overflow", overflow, w.overflow);
    endtask
  endclass

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, done, solvable, overflow;
  word_t ca = 0, cb = 0, cc = 0, cd = 0, ru = 0, rv = 0;
  word_t sx, sy;
  solution_board board = new();
  int unsigned idle_cycles = 0;

  linear_solve_2x2 dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .coef_a_i(ca), .coef_b_i(cb), .coef_c_i(cc), .coef_d_i(cd),
    .rhs_u_i(ru), .rhs_v_i(rv), .done_o(done), .solvable_o(solvable),
    .sol_x_o(sx), .sol_y_o(sy), .overflow_o(overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && done) board.check_solution(solvable, sx, sy, overflow);
    if ((rst_n && done) || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("linear_solve_2x2_test: errors");
      $finish;
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(9))
      0: return word_t'(32'h8000_0000);
      1: return word_t'(32'h7fff_ffff);
      2: return 0;
      3: return word_t'($urandom_range(65536 * 4)) - word_t'(65536 * 2);
      4: return word_t'(32'sd65536);
      default: return word_t'($urandom);
    endcase
  endfunction

  // holds start until the beat is taken, then drops it for a random gap, or keeps it high when the gap is zero
  task automatic send_system(input word_t a, b, c, d, u, v);
    int gap;
    ca <= a; cb <= b; cc <= c; cd <= d; ru <= u; rv <= v;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_system(a, b, c, d, u, v);
    @(negedge clk);
    gap = ($urandom_range(7) == 0) ? $urandom_range(40) : ($urandom_range(3) == 0);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    word_t a, b, c, d, k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // identity, singular, extremes and saturating systems
    send_system(65536, 0, 0, 65536, 123456, -98765);
    send_system(65536, 65536, 65536, 65536, 1, 2);
    send_system(0, 0, 0, 0, 0, 0);
    send_system(1, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000);
    send_system(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5, 5);
    send_system(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_system(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, -1, 1);
    send_system(1, 0, 0, -1, 32'h8000_0000, 32'h8000_0000);
    send_system(-65536, 3, 7, 65536 * 2, -1, -1);
    send_system(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, -1, -1);
    send_system(2, 1, 1, 1, 32'h7fff_ffff, 0);
    for (int i = 0; i < 1700; i++) begin
      a = pick_word(); b = pick_word(); c = pick_word(); d = pick_word();
      if ($urandom_range(9) == 0) begin
        // scaled rows give a singular system unless the scaled words wrap
        k = word_t'($urandom_range(8)) - 4;
        c = a * k; d = b * k;
      end
      send_system(a, b, c, d, pick_word(), pick_word());
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (ls2_pkg::LATENCY + 10) @(negedge clk);
    if (mismatch_count == 0) $display("linear_solve_2x2_test: clean");
    else $display("linear_solve_2x2_test: errors");
    $finish;
  end
endmodule
